// ===== hdl/des_pkg.sv =====
// ----------------------------------------------------------------------------
// des_pkg - shared types and codes of the delayed event scheduler
// Field widths, operation codes and event kinds used across the block.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = HANDLE_W + TIME_W;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [KIND_W-1:0]   kind_t;

  localparam op_t OP_SCHEDULE = 2'd0;
  localparam op_t OP_TICK     = 2'd1;
  localparam op_t OP_CLEAR    = 2'd2;

  localparam kind_t KIND_PLAYED  = 2'd0;
  localparam kind_t KIND_QUEUED  = 2'd1;
  localparam kind_t KIND_DROPPED = 2'd2;

  // Result of one countdown step on a slot
  typedef struct packed {
    logic  fire;
    time_t remain;
  } cmp_res_t;

endpackage

// ===== hdl/des_ram.sv =====
// ----------------------------------------------------------------------------
// des_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module des_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/des_cmp.sv =====
// ----------------------------------------------------------------------------
// des_cmp - countdown unit
// Subtract elapsed time from a slot wait; flag the slot when it expires.
// ----------------------------------------------------------------------------
module des_cmp
  import des_pkg::*;
(
  input  time_t    wait_val,
  input  time_t    elapsed,
  output cmp_res_t res
);

  logic [TIME_W:0] diff;

  assign diff       = {1'b0, wait_val} - {1'b0, elapsed};
  // fire when wait <= elapsed: borrow out or exact zero
  assign res.fire   = diff[TIME_W] | (diff[TIME_W-1:0] == '0);
  assign res.remain = diff[TIME_W-1:0];

endmodule

// ===== hdl/delayed_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// delayed_event_scheduler - table of countdown slots emitting delayed handles
// Schedule: delay 0 plays and a full table drops via the single result state;
// else a scan finds the lowest free slot. Tick: free slots are skipped, pending
// slots are read through one RAM read port and counted down by one shared unit.
// Clear and unused codes are done in idle. One item at a time.
// Reset (sync, active low) frees every slot; slot contents need no clearing.
// ----------------------------------------------------------------------------
module delayed_event_scheduler
  import des_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_operation,
  input  logic [15:0]   in_handle,
  input  logic [31:0]   in_delay,
  input  logic [31:0]   in_elapsed,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_event_handle,
  output logic [1:0]    out_event_kind,
  output logic          out_last_of_run
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W = $clog2(SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EMIT    = 3'd1;  // single schedule result
  localparam logic [2:0] ST_SCAN    = 3'd2;  // look for lowest free slot
  localparam logic [2:0] ST_TICK_RD = 3'd3;  // skip free slot or issue read
  localparam logic [2:0] ST_TICK_EX = 3'd4;  // count down the slot just read
  localparam logic [2:0] ST_TICK_END = 3'd5; // flush held beat as last

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SLOTS-1:0] pend_r, pend_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  handle_t          handle_r, handle_nxt;
  time_t            delay_r, delay_nxt;
  time_t            elapsed_r, elapsed_nxt;
  kind_t            kind_r, kind_nxt;

  // One fired handle held back until we know whether another follows
  logic             hold_v_r, hold_v_nxt;
  handle_t          hold_h_r, hold_h_nxt;

  // Output register
  logic             out_v_r, out_v_nxt;
  handle_t          out_h_r, out_h_nxt;
  kind_t            out_k_r, out_k_nxt;
  logic             out_l_r, out_l_nxt;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  handle_t            rd_handle;
  time_t              rd_wait;
  cmp_res_t           cmp_res;

  logic    can_push;
  logic    push;
  handle_t push_h;
  kind_t   push_k;
  logic    push_l;
  logic    last_idx;

  // Slot RAM: {handle, remaining wait}; read address follows the scan index,
  // so data for idx_r is valid in the cycle after the index settles.
  des_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_handle = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_wait   = ram_rdata[TIME_W-1:0];

  des_cmp u_cmp (
    .wait_val (rd_wait),
    .elapsed  (elapsed_r),
    .res      (cmp_res)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign can_push = !out_v_r || out_ready;
  assign last_idx = (idx_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    total_nxt   = total_r;
    handle_nxt  = handle_r;
    delay_nxt   = delay_r;
    elapsed_nxt = elapsed_r;
    kind_nxt    = kind_r;
    hold_v_nxt  = hold_v_r;
    hold_h_nxt  = hold_h_r;
    ram_we      = 1'b0;
    ram_wdata   = {handle_r, delay_r};
    push        = 1'b0;
    push_h      = handle_r;
    push_k      = kind_r;
    push_l      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          handle_nxt  = in_handle;
          delay_nxt   = in_delay;
          elapsed_nxt = in_elapsed;
          idx_nxt     = '0;
          case (in_operation)
            OP_SCHEDULE: begin
              if (in_delay == '0) begin
                kind_nxt  = KIND_PLAYED;
                state_nxt = ST_EMIT;
              end else if (total_r == TOT_W'(SLOTS)) begin
                kind_nxt  = KIND_DROPPED;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_TICK: begin
              // nothing pending: no beats at all
              if (total_r != '0) begin
                state_nxt = ST_TICK_RD;
              end
            end
            OP_CLEAR: begin
              pend_nxt  = '0;
              total_nxt = '0;
            end
            default: begin
              // unused code: drop it
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // a free slot is known to exist, so the scan always ends here
        if (!pend_r[idx_r]) begin
          ram_we           = 1'b1;
          pend_nxt[idx_r]  = 1'b1;
          total_nxt        = total_r + TOT_W'(1);
          kind_nxt         = KIND_QUEUED;
          state_nxt        = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_TICK_RD: begin
        if (pend_r[idx_r]) begin
          state_nxt = ST_TICK_EX;
        end else if (last_idx) begin
          state_nxt = ST_TICK_END;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_TICK_EX: begin
        if (cmp_res.fire) begin
          // release the held beat first; stall while the output is full
          if (!hold_v_r || can_push) begin
            if (hold_v_r) begin
              push   = 1'b1;
              push_h = hold_h_r;
              push_k = KIND_PLAYED;
              push_l = 1'b0;
            end
            hold_v_nxt      = 1'b1;
            hold_h_nxt      = rd_handle;
            pend_nxt[idx_r] = 1'b0;
            total_nxt       = total_r - TOT_W'(1);
            if (last_idx) begin
              state_nxt = ST_TICK_END;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_TICK_RD;
            end
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {rd_handle, cmp_res.remain};
          if (last_idx) begin
            state_nxt = ST_TICK_END;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_TICK_RD;
          end
        end
      end

      ST_TICK_END: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          push       = 1'b1;
          push_h     = hold_h_r;
          push_k     = KIND_PLAYED;
          push_l     = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load on push, drop once taken
  always_comb begin
    out_v_nxt = out_v_r;
    out_h_nxt = out_h_r;
    out_k_nxt = out_k_r;
    out_l_nxt = out_l_r;
    if (push) begin
      out_v_nxt = 1'b1;
      out_h_nxt = push_h;
      out_k_nxt = push_k;
      out_l_nxt = push_l;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= '0;
      total_r  <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      total_r  <= total_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r  <= handle_nxt;
    delay_r   <= delay_nxt;
    elapsed_r <= elapsed_nxt;
    kind_r    <= kind_nxt;
    hold_h_r  <= hold_h_nxt;
    out_h_r   <= out_h_nxt;
    out_k_r   <= out_k_nxt;
    out_l_r   <= out_l_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_event_handle = out_h_r;
  assign out_event_kind   = out_k_r;
  assign out_last_of_run  = out_l_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the delayed event scheduler
// Drives schedule, tick, clear and unused-code beats, predicts every played,
// queued and dropped event from a private copy of the slot table, and checks
// each result beat field by field in arrival order, under several idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import des_pkg::*;

  localparam int SLOTS = 16;
  localparam int PHASE_ITEMS = 112;
  // Unused operation code: the block must swallow it without a trace
  localparam op_t OP_UNUSED = 2'd3;

  // One row of the directed table. A row is repeated reps times, with the
  // handle and the delay stepped by one on each repeat. Where typed is set,
  // the single result of the row is given here instead of by the predictor.
  typedef struct packed {
    op_t     op;
    handle_t handle;
    time_t   delay;
    time_t   elapsed;
    int      reps;
    logic    typed;
    kind_t   kind;
  } stim_row_t;

  typedef struct packed {
    handle_t handle;
    kind_t   kind;
    logic    last;
  } event_t;

  localparam int N_ROWS = 13;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // tick on an empty table: nothing to emit
    '{OP_TICK,     16'h0000, 32'h0000_0000, 32'd5,         1,  1'b0, KIND_PLAYED},
    // zero delay plays at once, lowest handle
    '{OP_SCHEDULE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1,  1'b1, KIND_PLAYED},
    // unused code with every field at its top value
    '{OP_UNUSED,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b0, KIND_PLAYED},
    // clear with nothing pending
    '{OP_CLEAR,    16'h0000, 32'h0000_0000, 32'h0000_0000, 1,  1'b0, KIND_PLAYED},
    // longest possible wait lands in slot 0, top handle
    '{OP_SCHEDULE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1,  1'b1, KIND_QUEUED},
    // fill slots 1..15 with waits 1..15
    '{OP_SCHEDULE, 16'h0100, 32'h0000_0001, 32'h0000_0000, 15, 1'b1, KIND_QUEUED},
    // table full: drop
    '{OP_SCHEDULE, 16'h5A5A, 32'h0000_0007, 32'h0000_0000, 1,  1'b1, KIND_DROPPED},
    // zero elapsed: nothing fires
    '{OP_TICK,     16'h0000, 32'h0000_0000, 32'h0000_0000, 1,  1'b0, KIND_PLAYED},
    // waits 1..4 fire, the wait of 4 exactly on the boundary
    '{OP_TICK,     16'h0000, 32'h0000_0000, 32'h0000_0004, 1,  1'b0, KIND_PLAYED},
    // largest elapsed: everything left fires in one run
    '{OP_TICK,     16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1,  1'b0, KIND_PLAYED},
    // lowest free slot is slot 0 again
    '{OP_SCHEDULE, 16'h1234, 32'h0000_0003, 32'h0000_0000, 1,  1'b1, KIND_QUEUED},
    // clear with a slot pending
    '{OP_CLEAR,    16'h0000, 32'h0000_0000, 32'h0000_0000, 1,  1'b0, KIND_PLAYED},
    // the cleared slot must stay silent
    '{OP_TICK,     16'h0000, 32'h0000_0000, 32'h0000_0003, 1,  1'b0, KIND_PLAYED}
  };

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  op_t     in_operation = OP_SCHEDULE;
  handle_t in_handle = '0;
  time_t   in_delay = '0;
  time_t   in_elapsed = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  handle_t out_event_handle;
  kind_t   out_event_kind;
  logic    out_last_of_run;

  // Typed expectation travelling with the current input beat
  logic    row_typed = 1'b0;
  kind_t   row_kind = KIND_PLAYED;

  // Idle mix, in percent
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  // Shadow slot table
  logic    slot_armed [SLOTS];
  time_t   slot_left  [SLOTS];
  handle_t slot_tag   [SLOTS];

  event_t expected_events [$];

  int mismatch_count = 0;
  int items_accepted = 0;
  int events_checked = 0;
  int tick_plays = 0;
  int drops_seen = 0;

  delayed_event_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_handle        (in_handle),
    .in_delay         (in_delay),
    .in_elapsed       (in_elapsed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_handle (out_event_handle),
    .out_event_kind   (out_event_kind),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted beat to the shadow table and queue the events it causes
  function automatic void advance_schedule(op_t op, handle_t h, time_t d, time_t e);
    logic fires [SLOTS];
    int   last_idx;
    logic placed;
    last_idx = -1;
    placed = 1'b0;
    case (op)
      OP_SCHEDULE: begin
        if (d == '0) begin
          expected_events.push_back('{h, KIND_PLAYED, 1'b1});
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !slot_armed[i]) begin
              slot_armed[i] = 1'b1;
              slot_tag[i]   = h;
              slot_left[i]  = d;
              placed = 1'b1;
            end
          end
          expected_events.push_back('{h, placed ? KIND_QUEUED : KIND_DROPPED, 1'b1});
        end
      end
      OP_TICK: begin
        // Decide first which slots fire so the last one of the run is known
        for (int i = 0; i < SLOTS; i++) begin
          fires[i] = slot_armed[i] && (slot_left[i] <= e);
          if (fires[i]) last_idx = i;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (fires[i]) begin
            slot_armed[i] = 1'b0;
            expected_events.push_back('{slot_tag[i], KIND_PLAYED, i == last_idx});
          end else if (slot_armed[i]) begin
            slot_left[i] = slot_left[i] - e;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_armed[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("[%0t] ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Present one beat at the falling edge, hold it until it is taken
  task automatic send_beat(op_t op, handle_t h, time_t d, time_t e, logic typed, kind_t kind);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_handle    = h;
    in_delay     = d;
    in_elapsed   = e;
    row_typed    = typed;
    row_kind     = kind;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: stall at random, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watch both channels at the rising edge. Check output beats first; an
  // input beat taken at the same edge cannot have produced any of them yet.
  always @(posedge clk) begin : watch
    event_t want;
    int     queued_before;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        events_checked++;
        if (expected_events.size() == 0) begin
          report_mismatch("event with nothing pending, handle", 0, out_event_handle);
        end else begin
          want = expected_events.pop_front();
          if (out_event_handle !== want.handle)
            report_mismatch("event_handle", want.handle, out_event_handle);
          if (out_event_kind !== want.kind)
            report_mismatch("event_kind", want.kind, out_event_kind);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", want.last, out_last_of_run);
          if (want.kind == KIND_DROPPED) drops_seen++;
        end
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        queued_before = expected_events.size();
        advance_schedule(in_operation, in_handle, in_delay, in_elapsed);
        if (in_operation == OP_TICK) begin
          tick_plays += expected_events.size() - queued_before;
        end
        if (row_typed) begin
          // Swap in the hand-written result for this schedule beat
          void'(expected_events.pop_back());
          expected_events.push_back('{in_handle, row_kind, 1'b1});
        end
      end
    end
  end

  initial begin
    op_t   op;
    handle_t h;
    time_t d;
    time_t e;
    int    pick;
    int    counted;
    int    burst_left;
    logic  filling;
    int    idle_tab [4];
    int    stall_tab [4];
    idle_tab  = '{0, 45, 0, 32};
    stall_tab = '{0, 0, 45, 32};
    for (int i = 0; i < SLOTS; i++) begin
      slot_armed[i] = 1'b0;
      slot_left[i]  = '0;
      slot_tag[i]   = '0;
    end

    // Hold reset, then release it on a falling edge
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table, no idling on either side
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        send_beat(DIRECTED[r].op, DIRECTED[r].handle + handle_t'(k),
                  DIRECTED[r].delay + time_t'(k), DIRECTED[r].elapsed,
                  DIRECTED[r].typed, DIRECTED[r].kind);
      end
    end

    // Random part: one phase per idle mix. Within a phase, alternate between
    // filling bursts (mostly schedules, so the table runs full and drops) and
    // draining bursts (mostly ticks). Some bursts run with no idling at all.
    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      counted = 0;
      burst_left = 0;
      while (counted < PHASE_ITEMS) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(12, 28);
          filling = 1'($urandom_range(1));
          if ($urandom_range(3) == 0) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
          end else begin
            src_idle_pct  = idle_tab[ph];
            snk_stall_pct = stall_tab[ph];
          end
        end
        burst_left--;

        pick = $urandom_range(99);
        if (filling)
          op = (pick < 75) ? OP_SCHEDULE : (pick < 94) ? OP_TICK :
               (pick < 96) ? OP_CLEAR : OP_UNUSED;
        else
          op = (pick < 30) ? OP_SCHEDULE : (pick < 88) ? OP_TICK :
               (pick < 94) ? OP_CLEAR : OP_UNUSED;

        h = handle_t'($urandom);
        pick = $urandom_range(99);
        d = (pick < 8)  ? '0 :
            (pick < 18) ? time_t'($urandom) :
            (pick < 22) ? '1 : time_t'($urandom_range(1, 300));
        pick = $urandom_range(99);
        e = (pick < 10) ? '0 :
            (pick < 18) ? time_t'($urandom) :
            (pick < 22) ? '1 : time_t'($urandom_range(1, 120));

        send_beat(op, h, d, e, 1'b0, KIND_PLAYED);
        // Ignored beats do not count toward the phase
        if (op != OP_UNUSED) counted++;
      end
    end
    in_valid = 1'b0;

    // Drain: wait for every expected event, then idle out the longest tick
    while (expected_events.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("Covered %0d input beats (%0d directed rows) over four idle mixes.",
             items_accepted, N_ROWS);
    $display("Checked %0d events: %0d played by ticks, %0d dropped on a full table.",
             events_checked, tick_plays, drops_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/des_pkg.sv
hdl/des_ram.sv
hdl/des_cmp.sv
hdl/delayed_event_scheduler.sv
dv/tb_top.sv
